[src/fpa_pkg.sv]
// Shared types and command codes for the fixed-point ALU.
`default_nettype none
package fpa_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_GT  = 4'd4,
        CMD_LT  = 4'd5,
        CMD_GE  = 4'd6,
        CMD_LE  = 4'd7,
        CMD_EQ  = 4'd8,
        CMD_NE  = 4'd9,
        CMD_MIN = 4'd10,
        CMD_MAX = 4'd11,
        CMD_INC = 4'd12,
        CMD_DEC = 4'd13
    } cmd_t;

    typedef struct packed {
        logic        [3:0]        command;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } alu_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     compare_true;
        logic                     divide_by_zero;
    } alu_rsp_t;

endpackage
`default_nettype wire

[src/fpa_div.sv]
// Pipelined signed fixed-point divider, one quotient bit per stage.
`default_nettype none
module fpa_div
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic signed [DATA_W-1:0] a,
    input  wire logic signed [DATA_W-1:0] b,
    output logic                          out_valid,
    output logic signed [DATA_W-1:0]      quotient,
    output logic                          div_zero
);

    localparam int W = DATA_W + FRAC_BITS;

    logic              v_reg   [W+1];
    logic              neg_reg [W+1];
    logic              dz_reg  [W+1];
    logic [DATA_W-1:0] d_reg   [W+1];
    logic [DATA_W-1:0] rem_reg [W+1];
    logic [W-1:0]      dq_reg  [W+1];

    logic              v_next   [W+1];
    logic              neg_next [W+1];
    logic              dz_next  [W+1];
    logic [DATA_W-1:0] d_next   [W+1];
    logic [DATA_W-1:0] rem_next [W+1];
    logic [W-1:0]      dq_next  [W+1];

    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] quotient_reg;
    logic                     div_zero_reg;
    logic [W-1:0]             q_signed;

    assign a_mag = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
    assign b_mag = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);

    // load stage: magnitudes and scaled dividend
    always_comb
    begin
        v_next[0]   = in_valid;
        neg_next[0] = a[DATA_W-1] ^ b[DATA_W-1];
        dz_next[0]  = (b == '0);
        d_next[0]   = b_mag;
        rem_next[0] = '0;
        dq_next[0]  = {a_mag, {FRAC_BITS{1'b0}}};
    end

    // one restoring step per stage
    for (genvar k = 1; k <= W; k++)
    begin : g_step
        logic [DATA_W:0] trial;
        logic            fits;
        always_comb
        begin
            trial       = {rem_reg[k-1], dq_reg[k-1][W-1]};
            fits        = (trial >= {1'b0, d_reg[k-1]});
            v_next[k]   = v_reg[k-1];
            neg_next[k] = neg_reg[k-1];
            dz_next[k]  = dz_reg[k-1];
            d_next[k]   = d_reg[k-1];
            rem_next[k] = fits ? DATA_W'(trial - {1'b0, d_reg[k-1]})
                               : trial[DATA_W-1:0];
            dq_next[k]  = {dq_reg[k-1][W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k <= W; k++)
            begin
                v_reg[k] <= v_next[k];
            end
            out_valid_reg <= v_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= W; k++)
        begin
            neg_reg[k] <= neg_next[k];
            dz_reg[k]  <= dz_next[k];
            d_reg[k]   <= d_next[k];
            rem_reg[k] <= rem_next[k];
            dq_reg[k]  <= dq_next[k];
        end
        quotient_reg <= dz_reg[W] ? '0 : q_signed[DATA_W-1:0];
        div_zero_reg <= dz_reg[W];
    end

    assign q_signed  = neg_reg[W] ? W'(-dq_reg[W]) : dq_reg[W];
    assign out_valid = out_valid_reg;
    assign quotient  = quotient_reg;
    assign div_zero  = div_zero_reg;

endmodule
`default_nettype wire

[src/fpa_arith.sv]
// Add, multiply, compare and select path, delayed to match the divider.
`default_nettype none
module fpa_arith
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int LAT       = 42
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire alu_req_t req,
    output logic          out_valid,
    output logic          out_is_div,
    output alu_rsp_t      rsp
);

    localparam int DLY = LAT - 3;

    // stage 1: hold operands
    logic                     v1_reg;
    logic [3:0]               cmd1_reg;
    logic signed [DATA_W-1:0] a1_reg;
    logic signed [DATA_W-1:0] b1_reg;

    // stage 2: product and simple results
    logic                       v2_reg;
    logic [3:0]                 cmd2_reg;
    logic signed [2*DATA_W-1:0] prod2_reg;
    alu_rsp_t                   simple2_reg;
    alu_rsp_t                   simple_next;

    // stage 3 and delay line
    logic     v_reg   [DLY+1];
    logic     div_reg [DLY+1];
    alu_rsp_t rsp_reg [DLY+1];
    alu_rsp_t sel_next;

    always_comb
    begin
        simple_next = '0;
        case (cmd1_reg)
            CMD_ADD: simple_next.result_value = a1_reg + b1_reg;
            CMD_SUB: simple_next.result_value = a1_reg - b1_reg;
            CMD_GT:  simple_next.compare_true = (a1_reg >  b1_reg);
            CMD_LT:  simple_next.compare_true = (a1_reg <  b1_reg);
            CMD_GE:  simple_next.compare_true = (a1_reg >= b1_reg);
            CMD_LE:  simple_next.compare_true = (a1_reg <= b1_reg);
            CMD_EQ:  simple_next.compare_true = (a1_reg == b1_reg);
            CMD_NE:  simple_next.compare_true = (a1_reg != b1_reg);
            CMD_MIN: simple_next.result_value = (a1_reg < b1_reg) ? a1_reg : b1_reg;
            CMD_MAX: simple_next.result_value = (a1_reg > b1_reg) ? a1_reg : b1_reg;
            CMD_INC: simple_next.result_value = a1_reg + DATA_W'(1);
            CMD_DEC: simple_next.result_value = a1_reg - DATA_W'(1);
            default: simple_next = '0;
        endcase
    end

    always_comb
    begin
        sel_next = simple2_reg;
        if (cmd2_reg == CMD_MUL)
        begin
            sel_next.result_value = prod2_reg[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int k = 0; k <= DLY; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v_reg[0] <= v2_reg;
            for (int k = 1; k <= DLY; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg    <= req.command;
        a1_reg      <= req.operand_a;
        b1_reg      <= req.operand_b;
        cmd2_reg    <= cmd1_reg;
        prod2_reg   <= a1_reg * b1_reg;
        simple2_reg <= simple_next;
        rsp_reg[0]  <= sel_next;
        div_reg[0]  <= (cmd2_reg == CMD_DIV);
        for (int k = 1; k <= DLY; k++)
        begin
            rsp_reg[k] <= rsp_reg[k-1];
            div_reg[k] <= div_reg[k-1];
        end
    end

    assign out_valid  = v_reg[DLY];
    assign out_is_div = div_reg[DLY];
    assign rsp        = rsp_reg[DLY];

endmodule
`default_nettype wire

[src/fixed_point_alu.sv]
// Top level of the signed 32-bit fixed-point ALU.
//
// Usage:
//   Drive request (command, operand_a, operand_b) and raise start; the item
//   is taken at the rising edge where start is high and busy is low. busy is
//   always low: a new item may enter on every cycle.
//   Each item yields exactly one result on response, shown for one cycle
//   with done high. Results leave in the order the items came in.
// Path length: the same from accept edge to the done cycle for every
//   command. The divider sets this length: it resolves one quotient
//   bit per stage over 32 + FRAC_BITS stages, plus a load and an output
//   register. The other commands travel a short path (operand register,
//   multiplier register, select register) and then a delay line, so both
//   paths have equal length and line up.
// Throughput: one item per cycle.
// Reset: rst_n clears all valid bits; nothing is in flight afterwards.
// The receiver cannot stall: results are taken as they appear.
`default_nettype none
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire alu_req_t request,
    output logic          done,
    output alu_rsp_t      response
);

    // load register + one stage per quotient bit + output register
    localparam int LAT = DATA_W + FRAC_BITS + 2;

    logic                     accept;
    logic                     div_valid;
    logic signed [DATA_W-1:0] div_quotient;
    logic                     div_zero;
    logic                     ar_valid;
    logic                     ar_is_div;
    alu_rsp_t                 ar_rsp;

    // never hold off the sender
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    fpa_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .a         (request.operand_a),
        .b         (request.operand_b),
        .out_valid (div_valid),
        .quotient  (div_quotient),
        .div_zero  (div_zero)
    );

    fpa_arith #(
        .FRAC_BITS (FRAC_BITS),
        .LAT       (LAT)
    ) u_arith (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .req        (request),
        .out_valid  (ar_valid),
        .out_is_div (ar_is_div),
        .rsp        (ar_rsp)
    );

    // merge: take the divider's answer for divide items
    always_comb
    begin
        response = ar_rsp;
        if (ar_is_div)
        begin
            response.result_value   = div_quotient;
            response.compare_true   = 1'b0;
            response.divide_by_zero = div_zero;
        end
    end

    assign done = ar_valid;

    // both paths must stay aligned
    assert property (@(posedge clk) disable iff (!rst_n) ar_valid == div_valid)
        else $error("divider and arithmetic paths out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(response.compare_true && response.divide_by_zero))
        else $error("compare and divide flags both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.divide_by_zero) |-> (response.result_value == '0))
        else $error("divide by zero with non-zero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.compare_true) |-> (response.result_value == '0))
        else $error("comparison with non-zero result");

endmodule
`default_nettype wire
